// ===== rtl/core/tli_pkg.sv =====
`default_nettype none

package tli_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    localparam int OP_W        = 1;
    localparam int ENTRY_W     = 6;
    localparam int VAL_W       = 16;
    localparam int IDX_W       = 16;
    localparam int SIZE_W      = 7;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    // Shared serial divider: 32-bit dividend and 17-bit divisor.
    localparam int DIV_W       = 2 * VAL_W;
    localparam int DSR_W       = IDX_W + 1;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

    localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
    localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_IDX_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'b1;

    localparam logic [IDX_W-1:0]  IDX_LIMIT_RST  = 16'hFFFF;
    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 7'd64;

    typedef enum logic [3:0] {
        S_IDLE,
        S_END,
        S_MUL_SEG,
        S_DIV_SEG,
        S_MUL_X0,
        S_DIV_X0,
        S_MUL_X1,
        S_DIV_X1,
        S_RD_Y1,
        S_MUL_N,
        S_DIV_Q,
        S_FINISH,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/tli_req_if.sv =====
`default_nettype none

interface tli_req_if;
    import tli_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [ENTRY_W-1:0] entry_addr;
    logic [VAL_W-1:0]   entry_value;
    logic [IDX_W-1:0]   query_index;

    modport source (output valid, output op, output entry_addr, output entry_value,
                    output query_index, input ready);
    modport sink   (input valid, input op, input entry_addr, input entry_value,
                    input query_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tli_rsp_if.sv =====
`default_nettype none

interface tli_rsp_if;
    import tli_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tli_cfg_if.sv =====
`default_nettype none

interface tli_cfg_if;
    import tli_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/table_linear_interpolator.sv =====
// Linear-interpolating lookup table. Write items (op 0) store a 16-bit sample in a
// 64-entry synchronous RAM; they produce no result. Query items (op 1) return one
// interpolated value. A query at index zero or above the index limit (register 0)
// reads one entry, and its result moves from the RAM read register through the
// result register to the output register. Any other query runs three divisions
// (segment, segment start, segment end) and a final scaled division through one
// shared restoring divider that retires one quotient bit per cycle. A zero-width
// segment skips the last division. The block handles one item at a time; a
// finished result waits in an output register, so the next item can be taken while
// it is still unread. Configuration is always ready and must only be written while
// the block is idle. Every table entry must be written before a query reads it.
`default_nettype none

module table_linear_interpolator (
    input  wire         clk,
    input  wire         rst_n,
    tli_req_if.sink     req,
    tli_rsp_if.source   rsp,
    tli_cfg_if.sink     cfg
);
    import tli_pkg::*;

    logic [VAL_W-1:0]  mem [TABLE_DEPTH];

    state_t            state_reg, state_next;

    logic [IDX_W-1:0]  idx_limit_reg, idx_limit_next;
    logic [SIZE_W-1:0] table_size_reg, table_size_next;

    logic [IDX_W-1:0]  x_reg, x_next;
    logic [ADDR_W-1:0] seg_reg, seg_next;
    logic [ADDR_W-1:0] nxt_reg, nxt_next;
    logic [IDX_W-1:0]  x0_reg, x0_next;
    logic [VAL_W-1:0]  y0_reg, y0_next;
    logic              neg_reg, neg_next;
    logic [VAL_W-1:0]  res_reg, res_next;

    logic              out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]  out_value_reg, out_value_next;

    logic [DIV_W-1:0]     div_quo_reg, div_quo_next;
    logic [DSR_W-1:0]     div_rem_reg, div_rem_next;
    logic [DSR_W-1:0]     div_dsr_reg, div_dsr_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic [VAL_W-1:0]  rd_data_reg;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic              req_fire;
    logic [SIZE_W-1:0] eff_size;
    logic [SIZE_W-1:0] last_wide;
    logic [ADDR_W-1:0] last;
    logic              div_last_step;

    logic [VAL_W-1:0]  mul_a;
    logic [VAL_W-1:0]  mul_b;
    logic [DIV_W-1:0]  mul_prod;

    logic [DSR_W:0]    div_trial;
    logic [DSR_W:0]    div_diff;
    logic              div_fits;

    logic [ADDR_W-1:0] seg_c;
    logic [VAL_W:0]    dy;
    logic [VAL_W-1:0]  dy_mag;
    logic [IDX_W-1:0]  x1_val;
    logic [VAL_W-1:0]  q16;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.value = out_value_reg;

    always_comb
    begin
        if (table_size_reg < SIZE_W'(2))
        begin
            eff_size = SIZE_W'(2);
        end
        else if (table_size_reg > SIZE_W'(TABLE_DEPTH))
        begin
            eff_size = SIZE_W'(TABLE_DEPTH);
        end
        else
        begin
            eff_size = table_size_reg;
        end
        last_wide = eff_size - SIZE_W'(1);
        last      = last_wide[ADDR_W-1:0];
    end

    assign mul_prod = DIV_W'(mul_a) * DIV_W'(mul_b);

    // One restoring step: shift in the next dividend bit and subtract if it fits.
    assign div_trial     = {div_rem_reg, div_quo_reg[DIV_W-1]};
    assign div_fits      = (div_trial >= {1'b0, div_dsr_reg});
    assign div_diff      = div_trial - {1'b0, div_dsr_reg};
    assign div_last_step = (div_cnt_reg == DIV_CNT_W'(1));

    assign x1_val = div_quo_reg[IDX_W-1:0];
    assign q16    = div_quo_reg[VAL_W-1:0];
    assign seg_c  = (div_quo_reg > DIV_W'(last)) ? last : div_quo_reg[ADDR_W-1:0];
    assign dy     = {1'b0, rd_data_reg} - {1'b0, y0_reg};
    assign dy_mag = dy[VAL_W] ? VAL_W'(-dy) : dy[VAL_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire && (req.op == OP_QUERY))
                begin
                    if ((req.query_index == '0) || (req.query_index > idx_limit_reg))
                    begin
                        state_next = S_END;
                    end
                    else
                    begin
                        state_next = S_MUL_SEG;
                    end
                end
            end
            S_END:     state_next = S_DONE;
            S_MUL_SEG: state_next = S_DIV_SEG;
            S_DIV_SEG: state_next = div_last_step ? S_MUL_X0 : S_DIV_SEG;
            S_MUL_X0:  state_next = S_DIV_X0;
            S_DIV_X0:  state_next = div_last_step ? S_MUL_X1 : S_DIV_X0;
            S_MUL_X1:  state_next = S_DIV_X1;
            S_DIV_X1:  state_next = div_last_step ? S_RD_Y1 : S_DIV_X1;
            S_RD_Y1:   state_next = (x1_val <= x0_reg) ? S_DONE : S_MUL_N;
            S_MUL_N:   state_next = S_DIV_Q;
            S_DIV_Q:   state_next = div_last_step ? S_FINISH : S_DIV_Q;
            S_FINISH:  state_next = S_DONE;
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        idx_limit_next  = idx_limit_reg;
        table_size_next = table_size_reg;
        x_next          = x_reg;
        seg_next        = seg_reg;
        nxt_next        = nxt_reg;
        x0_next         = x0_reg;
        y0_next         = y0_reg;
        neg_next        = neg_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        div_quo_next    = div_quo_reg;
        div_rem_next    = div_rem_reg;
        div_dsr_next    = div_dsr_reg;
        div_cnt_next    = div_cnt_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        mul_a           = '0;
        mul_b           = '0;

        if (cfg.valid)
        begin
            case (cfg.index)
                REG_IDX_LIMIT:  idx_limit_next  = cfg.data[IDX_W-1:0];
                REG_TABLE_SIZE: table_size_next = cfg.data[SIZE_W-1:0];
                default:        ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.op == OP_WRITE)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        x_next = req.query_index;
                        if (req.query_index == '0)
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = '0;
                        end
                        else if (req.query_index > idx_limit_reg)
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = last;
                        end
                    end
                end
            end
            S_END:
            begin
                res_next = rd_data_reg;
            end
            S_MUL_SEG:
            begin
                mul_a        = x_reg;
                mul_b        = VAL_W'(last);
                div_quo_next = mul_prod;
                div_rem_next = '0;
                div_dsr_next = DSR_W'(idx_limit_reg) + DSR_W'(1);
                div_cnt_next = DIV_CNT_W'(DIV_W);
            end
            S_MUL_X0:
            begin
                seg_next     = seg_c;
                nxt_next     = (seg_c == last) ? last : seg_c + ADDR_W'(1);
                mul_a        = VAL_W'(seg_c);
                mul_b        = idx_limit_reg;
                div_quo_next = mul_prod;
                div_rem_next = '0;
                div_dsr_next = DSR_W'(last);
                div_cnt_next = DIV_CNT_W'(DIV_W);
            end
            S_MUL_X1:
            begin
                x0_next      = div_quo_reg[IDX_W-1:0];
                mem_re       = 1'b1;
                mem_raddr    = seg_reg;
                mul_a        = VAL_W'(nxt_reg);
                mul_b        = idx_limit_reg;
                div_quo_next = mul_prod;
                div_rem_next = '0;
                div_dsr_next = DSR_W'(last);
                div_cnt_next = DIV_CNT_W'(DIV_W);
            end
            S_RD_Y1:
            begin
                // The read data holds the segment start sample here.
                y0_next   = rd_data_reg;
                res_next  = rd_data_reg;
                mem_re    = 1'b1;
                mem_raddr = nxt_reg;
            end
            S_MUL_N:
            begin
                // Divide magnitudes and restore the sign afterward, which
                // truncates toward zero for falling segments.
                neg_next     = dy[VAL_W];
                mul_a        = x_reg - x0_reg;
                mul_b        = dy_mag;
                div_quo_next = mul_prod;
                div_rem_next = '0;
                div_dsr_next = DSR_W'(x1_val - x0_reg);
                div_cnt_next = DIV_CNT_W'(DIV_W);
            end
            S_FINISH:
            begin
                res_next = neg_reg ? (y0_reg - q16) : (y0_reg + q16);
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_reg;
                end
            end
            S_DIV_SEG, S_DIV_X0, S_DIV_X1, S_DIV_Q:
            begin
                div_quo_next = {div_quo_reg[DIV_W-2:0], div_fits};
                div_rem_next = div_fits ? div_diff[DSR_W-1:0] : div_trial[DSR_W-1:0];
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_limit_reg  <= IDX_LIMIT_RST;
            table_size_reg <= TABLE_SIZE_RST;
            out_valid_reg  <= 1'b0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_limit_reg  <= idx_limit_next;
            table_size_reg <= table_size_next;
            out_valid_reg  <= out_valid_next;
            div_cnt_reg    <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        seg_reg       <= seg_next;
        nxt_reg       <= nxt_next;
        x0_reg        <= x0_next;
        y0_reg        <= y0_next;
        neg_reg       <= neg_next;
        res_reg       <= res_next;
        out_value_reg <= out_value_next;
        div_quo_reg   <= div_quo_next;
        div_rem_reg   <= div_rem_next;
        div_dsr_reg   <= div_dsr_next;
    end

    // Sample RAM. Reads are never issued in the same cycle as a write,
    // since one item is handled at a time.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[req.entry_addr[ADDR_W-1:0]] <= req.entry_value;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb_table_linear_interpolator.sv =====
`timescale 1ns / 100ps

module tb_table_linear_interpolator;
    import tli_pkg::*;

    typedef enum logic [1:0] {ROW_CFG, ROW_WRITE, ROW_QUERY} row_kind_t;

    // For ROW_CFG, a is the index limit and b the table_size data. For ROW_WRITE, a is
    // the entry and b the sample. For ROW_QUERY, a is the index.
    typedef struct packed {
        row_kind_t        kind;
        logic [15:0]      a;
        logic [15:0]      b;
        logic             typed;
        logic [VAL_W-1:0] want;
    } script_row_t;

    localparam int SCRIPT_ROWS     = 26;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 66;

    logic clk;
    logic rst_n;

    tli_req_if req_bus();
    tli_rsp_if rsp_bus();
    tli_cfg_if cfg_bus();

    table_linear_interpolator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    logic [VAL_W-1:0]  samples [TABLE_DEPTH];
    bit                sample_written [TABLE_DEPTH];
    logic [IDX_W-1:0]  idx_limit_reg;
    logic [SIZE_W-1:0] table_size_reg;
    logic [VAL_W-1:0]  pending_values [$];
    script_row_t       script [SCRIPT_ROWS];

    bit no_gaps;
    int errors;
    int n_writes;
    int n_queries;
    int n_results;
    int n_settings;
    int rsp_stall;

    always #2 clk = ~clk;

    function automatic int draw_wait();
        return no_gaps ? 0 : int'($urandom_range(0, 11));
    endfunction

    function automatic int unsigned used_entries();
        int unsigned n = table_size_reg;
        if (n < 2)
            n = 2;
        if (n > TABLE_DEPTH)
            n = TABLE_DEPTH;
        return n;
    endfunction

    // Entries that a query at x reads; both are the same entry at the two ends.
    function automatic void find_segment(input logic [IDX_W-1:0] x,
                                         output int unsigned seg,
                                         output int unsigned nxt);
        int unsigned last;
        last = used_entries() - 1;
        if (x == 0) begin
            seg = 0;
            nxt = 0;
        end else if (x > idx_limit_reg) begin
            seg = last;
            nxt = last;
        end else begin
            seg = (32'(x) * last) / (32'(idx_limit_reg) + 32'd1);
            if (seg > last)
                seg = last;
            nxt = (seg == last) ? last : seg + 1;
        end
    endfunction

    function automatic logic [VAL_W-1:0] interpolate(input logic [IDX_W-1:0] x);
        int unsigned seg, nxt, last, x0, x1;
        longint y0, y1, xl, x0l, span, num, q;
        find_segment(x, seg, nxt);
        if (x == 0 || x > idx_limit_reg)
            return samples[seg];
        last = used_entries() - 1;
        x0 = (seg * 32'(idx_limit_reg)) / last;
        x1 = (nxt * 32'(idx_limit_reg)) / last;
        if (x1 <= x0)
            return samples[seg];
        y0 = samples[seg];
        y1 = samples[nxt];
        xl = x;
        x0l = x0;
        span = x1 - x0;
        // Signed division truncates toward zero, which falling segments rely on.
        num = (xl - x0l) * (y1 - y0);
        q = num / span;
        return VAL_W'(y0 + q);
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input logic [ENTRY_W-1:0] addr,
                             input logic [VAL_W-1:0] value, input logic [IDX_W-1:0] index,
                             input bit typed, input logic [VAL_W-1:0] want);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.op          <= op;
        req_bus.entry_addr  <= addr;
        req_bus.entry_value <= value;
        req_bus.query_index <= index;
        do @(posedge clk); while (!req_bus.ready);
        if (op == OP_WRITE) begin
            samples[addr] = value;
            sample_written[addr] = 1'b1;
            n_writes++;
        end else begin
            pending_values.push_back(typed ? want : interpolate(index));
            n_queries++;
        end
    endtask

    // A write item gives no result, so the task keeps waiting after the last result
    // before the block is taken as idle.
    task automatic drain();
        req_bus.valid <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_DATA_W-1:0] limit_data,
                                input logic [CFG_DATA_W-1:0] size_data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= REG_IDX_LIMIT;
        cfg_bus.data  <= limit_data;
        do @(posedge clk); while (!cfg_bus.ready);
        idx_limit_reg = limit_data[IDX_W-1:0];
        cfg_bus.index <= REG_TABLE_SIZE;
        cfg_bus.data  <= size_data;
        do @(posedge clk); while (!cfg_bus.ready);
        table_size_reg = size_data[SIZE_W-1:0];
        cfg_bus.valid <= 1'b0;
        n_settings++;
    endtask

    task automatic random_item();
        logic [OP_W-1:0]    op;
        logic [ENTRY_W-1:0] addr;
        logic [VAL_W-1:0]   value;
        logic [IDX_W-1:0]   x;
        int unsigned        seg, nxt, n;
        n = used_entries();
        op = ($urandom_range(0, 9) < 6) ? OP_QUERY : OP_WRITE;
        if ($urandom_range(0, 3) != 0)
            addr = ENTRY_W'($urandom_range(0, n - 1));
        else
            addr = ENTRY_W'($urandom);
        case ($urandom_range(0, 7))
            0:       value = '0;
            1:       value = '1;
            default: value = VAL_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0: x = '0;
            1: x = idx_limit_reg;
            2: x = (idx_limit_reg == '1) ? '1
                   : IDX_W'($urandom_range(int'(idx_limit_reg) + 1, 65535));
            3: x = '1;
            default: x = IDX_W'($urandom_range(1, (idx_limit_reg == 0) ? 1
                                                  : int'(idx_limit_reg)));
        endcase
        if (op == OP_QUERY) begin
            find_segment(x, seg, nxt);
            // A query must never read an entry that was not loaded, so load it first.
            if (!sample_written[seg]) begin
                op = OP_WRITE;
                addr = ENTRY_W'(seg);
            end else if (!sample_written[nxt]) begin
                op = OP_WRITE;
                addr = ENTRY_W'(nxt);
            end
        end
        send_item(op, addr, value, x, 1'b0, '0);
    endtask

    always @(posedge clk) begin : result_check
        logic [VAL_W-1:0] want;
        if (!rst_n) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall = 0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                n_results++;
                if (pending_values.size() == 0) begin
                    report_mismatch($sformatf("result %h with no query pending",
                                              rsp_bus.value));
                end else begin
                    want = pending_values.pop_front();
                    if (rsp_bus.value !== want)
                        report_mismatch($sformatf("value %h, expected %h",
                                                  rsp_bus.value, want));
                end
                rsp_stall = draw_wait();
            end else if (rsp_stall > 0) begin
                rsp_stall--;
            end
            rsp_bus.ready <= (rsp_stall == 0);
        end
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results still pending.", pending_values.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [IDX_W-1:0]  pmax;
        logic [SIZE_W-1:0] psize;
        script_row_t       row;

        clk = 1'b0;
        rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.op = OP_WRITE;
        req_bus.entry_addr = '0;
        req_bus.entry_value = '0;
        req_bus.query_index = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_IDX_LIMIT;
        cfg_bus.data = '0;
        no_gaps = 1'b0;
        errors = 0;
        n_writes = 0;
        n_queries = 0;
        n_results = 0;
        n_settings = 0;
        idx_limit_reg = IDX_LIMIT_RST;
        table_size_reg = TABLE_SIZE_RST;

        script = '{
            '{ROW_CFG,   16'd1000,  16'd2,     1'b0, 16'h0000},
            '{ROW_WRITE, 16'd0,     16'h0000,  1'b0, 16'h0000},
            '{ROW_WRITE, 16'd1,     16'hFFFF,  1'b0, 16'h0000},
            '{ROW_QUERY, 16'd0,     16'h0000,  1'b1, 16'h0000},
            '{ROW_QUERY, 16'hFFFF,  16'h0000,  1'b1, 16'hFFFF},
            '{ROW_QUERY, 16'd1000,  16'h0000,  1'b1, 16'hFFFF},
            '{ROW_QUERY, 16'd500,   16'h0000,  1'b0, 16'h0000},
            '{ROW_WRITE, 16'd0,     16'hFFFF,  1'b0, 16'h0000},
            '{ROW_WRITE, 16'd1,     16'h0000,  1'b0, 16'h0000},
            '{ROW_QUERY, 16'd1,     16'h0000,  1'b0, 16'h0000},
            '{ROW_QUERY, 16'd999,   16'h0000,  1'b0, 16'h0000},
            '{ROW_QUERY, 16'd1001,  16'h0000,  1'b1, 16'h0000},
            '{ROW_CFG,   16'd1,     16'd4,     1'b0, 16'h0000},
            '{ROW_WRITE, 16'd1,     16'h5A5A,  1'b0, 16'h0000},
            '{ROW_WRITE, 16'd2,     16'h1234,  1'b0, 16'h0000},
            '{ROW_WRITE, 16'd3,     16'hABCD,  1'b0, 16'h0000},
            '{ROW_QUERY, 16'd1,     16'h0000,  1'b1, 16'h5A5A},
            '{ROW_QUERY, 16'd2,     16'h0000,  1'b1, 16'hABCD},
            '{ROW_CFG,   16'd0,     16'd0,     1'b0, 16'h0000},
            '{ROW_QUERY, 16'd7,     16'h0000,  1'b1, 16'h5A5A},
            '{ROW_QUERY, 16'd0,     16'h0000,  1'b1, 16'hFFFF},
            '{ROW_CFG,   16'hFFFF,  16'h007F,  1'b0, 16'h0000},
            '{ROW_WRITE, 16'd62,    16'h8000,  1'b0, 16'h0000},
            '{ROW_WRITE, 16'd63,    16'h7FFF,  1'b0, 16'h0000},
            '{ROW_QUERY, 16'hFFFF,  16'h0000,  1'b0, 16'h0000},
            '{ROW_QUERY, 16'hFFFE,  16'h0000,  1'b0, 16'h0000}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < SCRIPT_ROWS; i++) begin
            row = script[i];
            case (row.kind)
                ROW_CFG: begin
                    drain();
                    write_config(row.a, row.b);
                end
                ROW_WRITE:
                    send_item(OP_WRITE, ENTRY_W'(row.a), row.b, IDX_W'($urandom),
                              1'b0, '0);
                default:
                    send_item(OP_QUERY, ENTRY_W'($urandom), VAL_W'($urandom), row.a,
                              row.typed, row.want);
            endcase
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin pmax = '1;        psize = 7'd64; end
                1: begin pmax = '0;        psize = 7'd64; end
                2: begin pmax = 16'd63;    psize = 7'd64; end
                3: begin pmax = 16'd1000;  psize = 7'd17; end
                4: begin pmax = '1;        psize = 7'd2;  end
                5: begin
                    pmax = IDX_W'($urandom_range(1, 65535));
                    psize = SIZE_W'($urandom_range(2, 64));
                end
                6: begin pmax = IDX_W'($urandom); psize = 7'd1; end
                default: begin pmax = 16'd40000; psize = 7'd127; end
            endcase
            drain();
            // Bits above the table_size field are don't-care and get random values.
            write_config(pmax, {(CFG_DATA_W - SIZE_W)'($urandom), psize});
            no_gaps = (phase % 3 == 1);
            repeat (ITEMS_PER_PHASE) random_item();
        end

        no_gaps = 1'b0;
        drain();
        repeat (120) @(posedge clk);

        $display("Ran %0d directed rows and %0d random phases over %0d register settings.",
                 SCRIPT_ROWS, RANDOM_PHASES, n_settings);
        $display("Loaded %0d samples, sent %0d queries, checked %0d results, %0d mismatches.",
                 n_writes, n_queries, n_results, errors);
        if (errors == 0 && pending_values.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== table_linear_interpolator.f =====
rtl/core/tli_pkg.sv
rtl/core/tli_req_if.sv
rtl/core/tli_rsp_if.sv
rtl/core/tli_cfg_if.sv
rtl/core/table_linear_interpolator.sv
dv/tb_table_linear_interpolator.sv
